// File: rtl/core/ajpc_pkg.sv
// Shared types and constants for the accelerometer jump peak counter.
`default_nettype none
package ajpc_pkg;

   localparam int SAMPLE_W    = 13;
   localparam int TIME_W      = 48;
   localparam int COUNT_W     = 16;
   localparam int THR_W       = 24;
   localparam int SQ_W        = 25;   // square of a 13-bit magnitude
   localparam int PROD_W      = 48;   // threshold times square
   localparam int FRAC_W      = 16;   // Q16 scaling of the ratio
   localparam int DIGIT_W     = 4;
   localparam int DIGIT_CNT   = THR_W / DIGIT_W;
   localparam int DIGIT_CNT_W = 3;
   localparam int DIV_W       = 32;
   localparam int DIVISOR_W   = 17;
   localparam int DIV_CNT_W   = 5;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 24;

   localparam logic [THR_W-1:0]   RISE_RESET = 24'd167772;
   localparam logic [THR_W-1:0]   FALL_RESET = 24'd41943;
   localparam logic [COUNT_W-1:0] RATE_NUM   = 16'd60000;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RISE = 1'b0,
      CSR_FALL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic [TIME_W-1:0]          time_ms;
      logic                       vibrating;
   } req_type;

   typedef struct packed {
      logic               jump_found;
      logic [COUNT_W-1:0] jump_total;
      logic [COUNT_W-1:0] avg_jumps_per_min;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic rise_hit;
      logic fall_hit;
   } ratio_status_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_status_type;

endpackage
`default_nettype wire

// File: rtl/core/ajpc_ratio_unit.sv
// Digit-serial squared-ratio compare of one window step against both thresholds.
`default_nettype none
module ajpc_ratio_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 first,
   input  wire logic signed [ajpc_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [ajpc_pkg::THR_W-1:0]           rise_thr,
   input  wire logic [ajpc_pkg::THR_W-1:0]           fall_thr,
   output ajpc_pkg::ratio_status_type                status
);

   logic [ajpc_pkg::SAMPLE_W-1:0]    mag;
   logic [ajpc_pkg::SQ_W-1:0]        sq;
   logic [ajpc_pkg::SQ_W-1:0]        sq_cur_ff, sq_cur_in;
   logic [ajpc_pkg::SQ_W-1:0]        den_ff, den_in;
   logic [ajpc_pkg::THR_W-1:0]       rise_sh_ff, rise_sh_in;
   logic [ajpc_pkg::THR_W-1:0]       fall_sh_ff, fall_sh_in;
   logic [ajpc_pkg::PROD_W-1:0]      acc_r_ff, acc_r_in;
   logic [ajpc_pkg::PROD_W-1:0]      acc_f_ff, acc_f_in;
   logic [ajpc_pkg::DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                             running_ff, running_in;
   logic                             done_ff, done_in;
   logic [ajpc_pkg::PROD_W-1:0]      num;
   logic [ajpc_pkg::SQ_W+ajpc_pkg::DIGIT_W-1:0] part_r, part_f;

   assign mag = sample[ajpc_pkg::SAMPLE_W-1] ? ajpc_pkg::SAMPLE_W'(-sample)
                                             : ajpc_pkg::SAMPLE_W'(sample);
   assign sq  = ajpc_pkg::SQ_W'(mag) * ajpc_pkg::SQ_W'(mag);

   // MSB-first digits of each threshold times the previous square
   assign part_r = den_ff * rise_sh_ff[ajpc_pkg::THR_W-1 -: ajpc_pkg::DIGIT_W];
   assign part_f = den_ff * fall_sh_ff[ajpc_pkg::THR_W-1 -: ajpc_pkg::DIGIT_W];

   assign num = ajpc_pkg::PROD_W'({sq_cur_ff, {ajpc_pkg::FRAC_W{1'b0}}});

   always_comb begin
      sq_cur_in  = sq_cur_ff;
      den_in     = den_ff;
      rise_sh_in = rise_sh_ff;
      fall_sh_in = fall_sh_ff;
      acc_r_in   = acc_r_ff;
      acc_f_in   = acc_f_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         sq_cur_in  = sq;
         den_in     = first ? sq : sq_cur_ff;
         rise_sh_in = rise_thr;
         fall_sh_in = fall_thr;
         acc_r_in   = '0;
         acc_f_in   = '0;
         cnt_in     = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         acc_r_in   = {acc_r_ff[ajpc_pkg::PROD_W-ajpc_pkg::DIGIT_W-1:0],
                       {ajpc_pkg::DIGIT_W{1'b0}}} + ajpc_pkg::PROD_W'(part_r);
         acc_f_in   = {acc_f_ff[ajpc_pkg::PROD_W-ajpc_pkg::DIGIT_W-1:0],
                       {ajpc_pkg::DIGIT_W{1'b0}}} + ajpc_pkg::PROD_W'(part_f);
         rise_sh_in = rise_sh_ff << ajpc_pkg::DIGIT_W;
         fall_sh_in = fall_sh_ff << ajpc_pkg::DIGIT_W;
         cnt_in     = cnt_ff + 1'b1;
         if (cnt_ff == ajpc_pkg::DIGIT_CNT_W'(ajpc_pkg::DIGIT_CNT - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      sq_cur_ff  <= sq_cur_in;
      den_ff     <= den_in;
      rise_sh_ff <= rise_sh_in;
      fall_sh_ff <= fall_sh_in;
      acc_r_ff   <= acc_r_in;
      acc_f_ff   <= acc_f_in;
   end

   assign status.done     = done_ff;
   assign status.rise_hit = num >= acc_r_ff;
   assign status.fall_hit = num <= acc_f_ff;

endmodule
`default_nettype wire

// File: rtl/core/ajpc_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module ajpc_serial_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ajpc_pkg::DIV_W-1:0]     dividend,
   input  wire logic [ajpc_pkg::DIVISOR_W-1:0] divisor,
   output ajpc_pkg::div_status_type            status
);

   logic [ajpc_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [ajpc_pkg::DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [ajpc_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [ajpc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           running_ff, running_in;
   logic                           done_ff, done_in;
   logic [ajpc_pkg::DIVISOR_W:0]   shifted;
   logic [ajpc_pkg::DIVISOR_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[ajpc_pkg::DIV_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      rem_in     = rem_ff;
      dsr_in     = dsr_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         dsr_in     = divisor;
         quo_in     = dividend;
         cnt_in     = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         // no borrow: the divisor fits, take it out and set the bit
         if (!diff[ajpc_pkg::DIVISOR_W]) begin
            rem_in = diff[ajpc_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[ajpc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[ajpc_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[ajpc_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ajpc_pkg::DIV_CNT_W'(ajpc_pkg::DIV_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule
`default_nettype wire

// File: rtl/core/accel_jump_peak_counter_unit.sv
// Top level of the accelerometer jump peak counter.
//
// Samples enter on req_valid/req_ready with req_data; one result per sample
// leaves on rsp_valid/rsp_ready with rsp_data. Thresholds are written through
// csr_we/csr_addr/csr_wdata; the user must write them only while the block is
// idle, as the block itself does not enforce this. One sample is worked at a
// time; req_ready is high only between samples. A discarded (vibrating)
// sample goes straight to the result, a window with a zero oldest entry skips
// the scan, and a kept sample walks every window entry through the digit-serial
// ratio unit. A jump after the first adds two serial divisions, one for the
// rate estimate and one for the running average; an interval of 0 or above
// 60000 ms skips the first division. Once the result is registered, the block
// returns to idle and accepts the next sample.
// The result sits in an output register: the next sample is accepted while it
// waits, and the block holds a finished result until rsp_ready frees the slot.
// Synchronous reset clears the window, jump count, rate average, last jump
// time, and restores the threshold reset values.
`default_nettype none
module accel_jump_peak_counter_unit #(
   parameter int WINDOW_DEPTH = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire ajpc_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output ajpc_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [ajpc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [ajpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int STEP_W = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_SCAN_START = 12'b0000_0000_0010,
      ST_SCAN_LOAD  = 12'b0000_0000_0100,
      ST_SCAN_WAIT  = 12'b0000_0000_1000,
      ST_DECIDE     = 12'b0000_0001_0000,
      ST_EST        = 12'b0000_0010_0000,
      ST_EST_WAIT   = 12'b0000_0100_0000,
      ST_MUL        = 12'b0000_1000_0000,
      ST_AVG        = 12'b0001_0000_0000,
      ST_AVG_WAIT   = 12'b0010_0000_0000,
      ST_UPDATE     = 12'b0100_0000_0000,
      ST_DONE       = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [ajpc_pkg::SAMPLE_W-1:0] win_ff [WINDOW_DEPTH];
   logic signed [ajpc_pkg::SAMPLE_W-1:0] win_in [WINDOW_DEPTH];
   logic [ajpc_pkg::THR_W-1:0]   rise_thr_ff, rise_thr_in;
   logic [ajpc_pkg::THR_W-1:0]   fall_thr_ff, fall_thr_in;
   logic [ajpc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [ajpc_pkg::COUNT_W-1:0] avg_ff, avg_in;
   logic [ajpc_pkg::TIME_W-1:0]  last_ff, last_in;
   logic [ajpc_pkg::TIME_W-1:0]  time_ff, time_in;
   logic [ajpc_pkg::TIME_W-1:0]  dt_ff, dt_in;
   logic [ajpc_pkg::COUNT_W-1:0] est_ff, est_in;
   logic [ajpc_pkg::DIV_W-1:0]   prod_ff, prod_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         rise_ff, rise_in;
   logic                         fall_ff, fall_in;
   logic                         found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ajpc_pkg::rsp_type            rsp_ff, rsp_in;

   logic signed [ajpc_pkg::SAMPLE_W-1:0] scan_x;
   logic                                 ratio_start;
   ajpc_pkg::ratio_status_type           ratio_st;
   logic                                 div_start;
   logic [ajpc_pkg::DIV_W-1:0]           div_dividend;
   logic [ajpc_pkg::DIVISOR_W-1:0]       div_divisor;
   ajpc_pkg::div_status_type             div_st;
   logic                                 rise_now;

   // a zero entry walks as 1
   assign scan_x = (win_ff[0] != '0) ? win_ff[0]
                                     : ajpc_pkg::SAMPLE_W'(1);
   assign ratio_start = (state_ff == ST_SCAN_LOAD);
   assign rise_now    = rise_ff | ratio_st.rise_hit;

   ajpc_ratio_unit u_ratio (
      .clock    (clock),
      .reset    (reset),
      .start    (ratio_start),
      .first    (step_ff == '0),
      .sample   (scan_x),
      .rise_thr (rise_thr_ff),
      .fall_thr (fall_thr_ff),
      .status   (ratio_st)
   );

   assign div_dividend = (state_ff == ST_EST) ? ajpc_pkg::DIV_W'(ajpc_pkg::RATE_NUM)
                                              : prod_ff;
   assign div_divisor  = (state_ff == ST_EST) ? dt_ff[ajpc_pkg::DIVISOR_W-1:0]
                                              : ({1'b0, count_ff} + 1'b1);
   assign div_start    = (state_ff == ST_AVG) ||
                         ((state_ff == ST_EST) && (dt_ff != '0) &&
                          (dt_ff <= ajpc_pkg::TIME_W'(ajpc_pkg::RATE_NUM)));

   ajpc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_st)
   );

   // threshold registers
   always_comb begin
      rise_thr_in = rise_thr_ff;
      fall_thr_in = fall_thr_ff;
      if (csr_we) begin
         unique case (ajpc_pkg::csr_index_type'(csr_addr))
            ajpc_pkg::CSR_RISE: rise_thr_in = csr_wdata;
            ajpc_pkg::CSR_FALL: fall_thr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      count_in     = count_ff;
      avg_in       = avg_ff;
      last_in      = last_ff;
      time_in      = time_ff;
      dt_in        = dt_ff;
      est_in       = est_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               found_in = 1'b0;
               time_in  = req_data.time_ms;
               if (req_data.vibrating) begin
                  state_in = ST_DONE;
               end else begin
                  for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                     win_in[i] = win_ff[i+1];
                  end
                  win_in[WINDOW_DEPTH-1] = req_data.accel_x;
                  state_in = ST_SCAN_START;
               end
            end
         end
         ST_SCAN_START: begin
            step_in = '0;
            rise_in = 1'b0;
            fall_in = 1'b0;
            state_in = (win_ff[0] == '0) ? ST_DONE : ST_SCAN_LOAD;
         end
         ST_SCAN_LOAD: begin
            // rotate so the window is back in place after a full walk
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WINDOW_DEPTH-1] = win_ff[0];
            state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            if (ratio_st.done) begin
               rise_in = rise_now;
               fall_in = fall_ff | (rise_now & ratio_st.fall_hit);
               if (step_ff == STEP_W'(WINDOW_DEPTH - 1)) begin
                  state_in = ST_DECIDE;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_SCAN_LOAD;
               end
            end
         end
         ST_DECIDE: begin
            if (rise_ff && fall_ff) begin
               found_in = 1'b1;
               for (int i = 0; i < WINDOW_DEPTH; i++) begin
                  win_in[i] = '0;
               end
               dt_in    = time_ff - last_ff;
               state_in = (count_ff == '0) ? ST_UPDATE : ST_EST;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EST: begin
            if (dt_ff == '0) begin
               est_in   = ajpc_pkg::RATE_NUM;
               state_in = ST_MUL;
            end else if (dt_ff > ajpc_pkg::TIME_W'(ajpc_pkg::RATE_NUM)) begin
               est_in   = '0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_EST_WAIT;
            end
         end
         ST_EST_WAIT: begin
            if (div_st.done) begin
               est_in   = div_st.quotient[ajpc_pkg::COUNT_W-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = ajpc_pkg::DIV_W'(avg_ff) * ajpc_pkg::DIV_W'(count_ff)
                       + ajpc_pkg::DIV_W'(est_ff);
            state_in = ST_AVG;
         end
         ST_AVG: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_st.done) begin
               avg_in   = div_st.quotient[ajpc_pkg::COUNT_W-1:0];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (count_ff != ajpc_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            last_in  = time_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.jump_found        = found_ff;
               rsp_in.jump_total        = count_ff;
               rsp_in.avg_jumps_per_min = avg_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rise_thr_ff  <= ajpc_pkg::RISE_RESET;
         fall_thr_ff  <= ajpc_pkg::FALL_RESET;
         count_ff     <= '0;
         avg_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rise_thr_ff  <= rise_thr_in;
         fall_thr_ff  <= fall_thr_in;
         count_ff     <= count_in;
         avg_ff       <= avg_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      time_ff  <= time_in;
      dt_ff    <= dt_in;
      est_ff   <= est_in;
      prod_ff  <= prod_in;
      step_ff  <= step_in;
      rise_ff  <= rise_in;
      fall_ff  <= fall_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: verif/accel_jump_peak_counter_unit_tb.sv
// Self-checking testbench for the accelerometer jump peak counter unit.
`timescale 1ns / 100ps
module accel_jump_peak_counter_unit_tb;

   localparam int WINDOW_DEPTH   = 4;
   localparam int SETTLE_CYCLES  = 150;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ajpc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ajpc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [ajpc_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [ajpc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   accel_jump_peak_counter_unit #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted copy of the block's state and thresholds
   int pred_window [WINDOW_DEPTH];
   logic [ajpc_pkg::COUNT_W-1:0] pred_jump_count = '0;
   logic [ajpc_pkg::COUNT_W-1:0] pred_rate_avg = '0;
   logic [ajpc_pkg::TIME_W-1:0] pred_last_jump_ms = '0;
   logic [ajpc_pkg::THR_W-1:0] pred_rise_thr = ajpc_pkg::RISE_RESET;
   logic [ajpc_pkg::THR_W-1:0] pred_fall_thr = ajpc_pkg::FALL_RESET;

   ajpc_pkg::rsp_type expected_results [$];
   ajpc_pkg::rsp_type expected_head;
   int failure_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked = 0;
   int holds_granted = 0;
   int hold_left = 0;
   logic [ajpc_pkg::TIME_W-1:0] sample_clock_ms = '0;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // walk oldest to newest: rise first, then fall at the same or a later step
   function automatic bit window_has_peak();
      int prev_mag;
      int cur_mag;
      int i;
      longint unsigned num;
      longint unsigned den;
      bit rise;
      bit fall;
      rise = 1'b0;
      fall = 1'b0;
      if (pred_window[0] == 0) return 1'b0;
      prev_mag = magnitude(pred_window[0]);
      for (i = 0; i < WINDOW_DEPTH; i++) begin
         cur_mag = (pred_window[i] == 0) ? 1 : magnitude(pred_window[i]);
         num = 64'(cur_mag * cur_mag) << ajpc_pkg::FRAC_W;
         den = 64'(prev_mag * prev_mag);
         if (num >= 64'(pred_rise_thr) * den) rise = 1'b1;
         if (rise && num <= 64'(pred_fall_thr) * den) fall = 1'b1;
         prev_mag = cur_mag;
      end
      return rise && fall;
   endfunction

   function automatic ajpc_pkg::rsp_type predict_jump_result(input ajpc_pkg::req_type item);
      ajpc_pkg::rsp_type res;
      logic [ajpc_pkg::TIME_W-1:0] dt;
      longint unsigned estimate;
      longint unsigned acc;
      int i;
      res = '0;
      if (!item.vibrating) begin
         for (i = 0; i < WINDOW_DEPTH - 1; i++) pred_window[i] = pred_window[i + 1];
         pred_window[WINDOW_DEPTH - 1] = int'($signed(item.accel_x));
         if (window_has_peak()) begin
            res.jump_found = 1'b1;
            for (i = 0; i < WINDOW_DEPTH; i++) pred_window[i] = 0;
            if (pred_jump_count != 0) begin
               dt = item.time_ms - pred_last_jump_ms;
               estimate = (dt == 0) ? 64'(ajpc_pkg::RATE_NUM)
                                    : 64'(ajpc_pkg::RATE_NUM) / 64'(dt);
               acc = 64'(pred_rate_avg) * 64'(pred_jump_count) + estimate;
               pred_rate_avg = ajpc_pkg::COUNT_W'(acc / (64'(pred_jump_count) + 64'd1));
            end
            if (pred_jump_count != ajpc_pkg::COUNT_MAX)
               pred_jump_count = pred_jump_count + 1'b1;
            pred_last_jump_ms = item.time_ms;
         end
      end
      res.jump_total = pred_jump_count;
      res.avg_jumps_per_min = pred_rate_avg;
      return res;
   endfunction

   function automatic logic [ajpc_pkg::TIME_W-1:0] next_timestamp();
      int pick;
      pick = $urandom_range(99);
      if (pick < 3) begin
         // jump anywhere, forward or backward
         sample_clock_ms = ajpc_pkg::TIME_W'({$urandom, $urandom});
      end else if (pick >= 8) begin
         sample_clock_ms = sample_clock_ms + $urandom_range(1, 3000);
      end
      return sample_clock_ms;
   endfunction

   function automatic int random_accel();
      return int'($signed(ajpc_pkg::SAMPLE_W'($urandom)));
   endfunction

   // offer one sample; valid stays up after the transfer unless a gap follows
   task automatic offer_sample(input int ax, input logic [ajpc_pkg::TIME_W-1:0] t,
                               input bit vib);
      ajpc_pkg::req_type item;
      int gap;
      item.accel_x = ajpc_pkg::SAMPLE_W'(ax);
      item.time_ms = t;
      item.vibrating = vib;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_results.push_back(predict_jump_result(item));
   endtask

   // base, steep rise, sharp fall, back to base
   task automatic send_jump_pattern(input int base, input logic [ajpc_pkg::TIME_W-1:0] t);
      offer_sample(base, t, 1'b0);
      offer_sample(3 * base, t, 1'b0);
      offer_sample(base / 4, t, 1'b0);
      offer_sample(base, t, 1'b0);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_thresholds(input logic [ajpc_pkg::THR_W-1:0] rise,
                                   input logic [ajpc_pkg::THR_W-1:0] fall);
      wait_until_drained();
      csr_we <= 1'b1;
      csr_addr <= ajpc_pkg::CSR_RISE;
      csr_wdata <= rise;
      @(posedge clock);
      csr_addr <= ajpc_pkg::CSR_FALL;
      csr_wdata <= fall;
      @(posedge clock);
      csr_we <= 1'b0;
      pred_rise_thr = rise;
      pred_fall_thr = fall;
   endtask

   // mostly jump-shaped runs with random content, some noise and discards
   task automatic send_random_samples(input int count);
      int sent;
      int pick;
      int base;
      int peak;
      int drop;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            base = $urandom_range(1, 1365);
            if ($urandom_range(1)) base = -base;
            peak = base * int'($urandom_range(2, 3));
            drop = $urandom_range(0, magnitude(peak) / 2);
            if ($urandom_range(1)) drop = -drop;
            offer_sample(base, next_timestamp(), 1'b0);
            offer_sample(peak, next_timestamp(), 1'b0);
            offer_sample(drop, next_timestamp(), 1'b0);
            offer_sample(random_accel(), next_timestamp(), 1'b0);
            sent += 4;
         end else if (pick < 88) begin
            offer_sample(random_accel(), next_timestamp(), 1'b0);
            sent++;
         end else begin
            offer_sample(random_accel(), next_timestamp(), 1'b1);
         end
      end
   endtask

   task automatic test_discard_and_extremes();
      offer_sample(1234, 48'd5, 1'b1);
      offer_sample(-4096, 48'd0, 1'b0);
      offer_sample(4095, 48'hFFFF_FFFF_FFFF, 1'b0);
      offer_sample(0, 48'd7, 1'b0);
      offer_sample(-1, 48'd9, 1'b0);
   endtask

   task automatic test_first_jump();
      send_jump_pattern(100, 48'd1000);
   endtask

   task automatic test_zero_counts_as_one();
      offer_sample(1, 48'd2000, 1'b0);
      offer_sample(0, 48'd2000, 1'b0);
      offer_sample(2, 48'd2000, 1'b0);
      offer_sample(0, 48'd2000, 1'b0);
   endtask

   task automatic test_zero_interval();
      send_jump_pattern(200, 48'd2000);
   endtask

   task automatic test_far_future();
      send_jump_pattern(-500, 48'hFFFF_FFFF_FFF0);
   endtask

   task automatic test_time_wrap();
      send_jump_pattern(40, 48'd5);
   endtask

   task automatic test_random_traffic(input int count);
      write_thresholds(ajpc_pkg::RISE_RESET, ajpc_pkg::FALL_RESET);
      send_random_samples(count);
   endtask

   task automatic test_threshold_extremes();
      // everything rises and falls: any nonzero oldest entry is a jump
      write_thresholds('0, '1);
      send_random_samples(150);
      // fall can never be met
      write_thresholds('1, '0);
      send_random_samples(150);
   endtask

   task automatic test_rise_and_fall_same_step();
      write_thresholds(24'd65536, 24'd65536);
      send_random_samples(150);
   endtask

   task automatic test_random_thresholds();
      repeat (3) begin
         write_thresholds(ajpc_pkg::THR_W'($urandom_range(65536, 600000)),
                          ajpc_pkg::THR_W'($urandom_range(0, 65536)));
         send_random_samples(100);
      end
   endtask

   task automatic test_receiver_backpressure();
      write_thresholds(ajpc_pkg::RISE_RESET, ajpc_pkg::FALL_RESET);
      holds_asked++;
      send_random_samples(100);
   endtask

   always @(posedge clock) begin
      if (holds_granted != holds_asked) begin
         holds_granted <= holds_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: %p", rsp_data);
            failure_count++;
         end else begin
            expected_head = expected_results.pop_front();
            if (rsp_data.jump_found !== expected_head.jump_found) begin
               $error("jump_found: expected %0d, actual %0d",
                      expected_head.jump_found, rsp_data.jump_found);
               failure_count++;
            end
            if (rsp_data.jump_total !== expected_head.jump_total) begin
               $error("jump_total: expected %0d, actual %0d",
                      expected_head.jump_total, rsp_data.jump_total);
               failure_count++;
            end
            if (rsp_data.avg_jumps_per_min !== expected_head.avg_jumps_per_min) begin
               $error("avg_jumps_per_min: expected %0d, actual %0d",
                      expected_head.avg_jumps_per_min, rsp_data.avg_jumps_per_min);
               failure_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("accel_jump_peak_counter_unit_tb NOT OK");
      $finish;
   end

   initial begin
      for (int i = 0; i < WINDOW_DEPTH; i++) pred_window[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      recv_idle_pct = 60;
      test_discard_and_extremes();
      test_first_jump();
      test_zero_counts_as_one();
      test_zero_interval();
      test_far_future();
      test_time_wrap();
      test_random_traffic(500);

      send_idle_pct = 60;
      recv_idle_pct = 33;
      test_threshold_extremes();
      test_rise_and_fall_same_step();
      test_random_thresholds();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_receiver_backpressure();
      test_random_traffic(400);

      wait_until_drained();
      if (expected_results.size() != 0) failure_count++;
      if (failure_count == 0) begin
         $display("accel_jump_peak_counter_unit_tb OK");
      end else begin
         $display("accel_jump_peak_counter_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
